@@ rtl/core/ws2812_pixel_bit_encoder_defines.svh @@
// Assertion helpers shared by the encoder modules.
// Each expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef WS2812_PIXEL_BIT_ENCODER_DEFINES_SVH
`define WS2812_PIXEL_BIT_ENCODER_DEFINES_SVH

// Same-cycle implication
`define WSENC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define WSENC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/wsenc_pkg.sv @@
package wsenc_pkg;

  localparam int unsigned DataSymbols = 24;
  localparam int unsigned TickW       = 15;

  // Register reset values
  localparam logic [7:0]       BrightnessRst = 8'd50;
  localparam logic [TickW-1:0] ZeroHighRst   = 15'd4;
  localparam logic [TickW-1:0] ZeroLowRst    = 15'd8;
  localparam logic [TickW-1:0] OneHighRst    = 15'd7;
  localparam logic [TickW-1:0] OneLowRst     = 15'd6;
  localparam logic [TickW-1:0] ResetTickRst  = 15'd500;

  typedef enum logic [2:0] {
    REG_BRIGHTNESS = 3'd0,
    REG_ZERO_HIGH  = 3'd1,
    REG_ZERO_LOW   = 3'd2,
    REG_ONE_HIGH   = 3'd3,
    REG_ONE_LOW    = 3'd4,
    REG_RESET      = 3'd5
  } wsenc_reg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_led;
  } wsenc_pix_t;

  typedef struct packed {
    logic             first_level;
    logic [TickW-1:0] first_ticks;
    logic             second_level;
    logic [TickW-1:0] second_ticks;
    logic             last;
  } wsenc_sym_t;

  typedef struct packed {
    logic [2:0]       index;
    logic [TickW-1:0] value;
  } wsenc_cfg_wr_t;

  // Scaled colour word (green, red, blue) and frame flag, as queued
  typedef struct packed {
    logic [DataSymbols-1:0] word;
    logic                   last_led;
  } wsenc_item_t;

  // Tick settings handed to the serialiser
  typedef struct packed {
    logic [TickW-1:0] zero_high;
    logic [TickW-1:0] zero_low;
    logic [TickW-1:0] one_high;
    logic [TickW-1:0] one_low;
    logic [TickW-1:0] reset_low;
  } wsenc_timing_t;

  // floor(p / 255) for p <= 255*255
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = 17'(p) + 17'(p[15:8]) + 17'd1;
    return s[15:8];
  endfunction

endpackage

@@ rtl/core/wsenc_stream_if.sv @@
interface wsenc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/wsenc_front.sv @@
`include "ws2812_pixel_bit_encoder_defines.svh"

module wsenc_front
  import wsenc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  brightness,
  input  logic        pix_valid,
  output logic        pix_ready,
  input  wsenc_pix_t  pix,
  output logic        push_valid,
  input  logic        push_ready,
  output wsenc_item_t push_item
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [15:0] prod_r_r, prod_g_r, prod_b_r;
  logic        last_r;
  logic        take;

  assign pix_ready    = !s1_valid_r || push_ready;
  assign take         = pix_valid && pix_ready;
  assign s1_valid_nxt = take || (s1_valid_r && !push_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // products of each channel with brightness
  always_ff @(posedge clk) begin
    if (take) begin
      prod_r_r <= 16'(pix.red)   * 16'(brightness);
      prod_g_r <= 16'(pix.green) * 16'(brightness);
      prod_b_r <= 16'(pix.blue)  * 16'(brightness);
      last_r   <= pix.last_led;
    end
  end

  // green, red, blue: most significant byte goes out first
  assign push_valid         = s1_valid_r;
  assign push_item.word     = {div255(prod_g_r), div255(prod_r_r), div255(prod_b_r)};
  assign push_item.last_led = last_r;

  `WSENC_ASSERT_NEXT(a_front_hold, s1_valid_r && !push_ready,
    s1_valid_r && $stable(prod_g_r) && $stable(last_r), "front stage lost a stalled item")

endmodule

@@ rtl/core/wsenc_queue.sv @@
`include "ws2812_pixel_bit_encoder_defines.svh"

module wsenc_queue
  import wsenc_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  output logic        push_ready,
  input  wsenc_item_t push_item,
  output logic        head_valid,
  input  logic        pop,
  output wsenc_item_t head
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  wsenc_item_t         slot_r [DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     count_r, count_nxt;
  logic                do_push, do_pop;

  assign push_ready = count_r != CntW'(DEPTH);
  assign head_valid = count_r != '0;
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  `WSENC_ASSERT_NEXT(a_queue_fill, do_push && !do_pop,
    count_r == $past(count_r) + 1'b1, "queue count failed to track a push")

endmodule

@@ rtl/core/wsenc_back.sv @@
`include "ws2812_pixel_bit_encoder_defines.svh"

module wsenc_back
  import wsenc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  wsenc_timing_t timing,
  input  logic          head_valid,
  input  wsenc_item_t   head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output wsenc_sym_t    out_sym
);

  localparam int unsigned IdxW = $clog2(DataSymbols + 1);

  logic [IdxW-1:0]        idx_r, idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  wsenc_sym_t             sym_r, sym_nxt;
  logic [DataSymbols-1:0] shifted;
  logic                   emit, is_reset, final_sym, bit_val;

  assign emit      = head_valid && (!out_valid_r || out_ready);
  assign is_reset  = idx_r == IdxW'(DataSymbols);
  assign final_sym = is_reset || (idx_r == IdxW'(DataSymbols - 1) && !head.last_led);
  assign shifted   = head.word << idx_r;
  assign bit_val   = shifted[DataSymbols-1];
  assign pop       = emit && final_sym;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    sym_nxt       = sym_r;
    if (emit) begin
      idx_nxt              = final_sym ? '0 : idx_r + 1'b1;
      out_valid_nxt        = 1'b1;
      sym_nxt.first_level  = !is_reset;
      sym_nxt.second_level = 1'b0;
      sym_nxt.last         = final_sym;
      if (is_reset) begin
        sym_nxt.first_ticks  = timing.reset_low;
        sym_nxt.second_ticks = '0;
      end else if (bit_val) begin
        sym_nxt.first_ticks  = timing.one_high;
        sym_nxt.second_ticks = timing.one_low;
      end else begin
        sym_nxt.first_ticks  = timing.zero_high;
        sym_nxt.second_ticks = timing.zero_low;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_sym   = sym_r;

  `WSENC_ASSERT_NOW(a_reset_sym_owner, idx_r == IdxW'(DataSymbols),
    head_valid && head.last_led, "reset symbol pending without a last LED at the head")
  `WSENC_ASSERT_NOW(a_idx_range, 1'b1,
    idx_r <= IdxW'(DataSymbols), "symbol index ran past the reset symbol")

endmodule

@@ rtl/core/ws2812_pixel_bit_encoder.sv @@
// LED bit encoder: each transaction on in_pix is one LED colour. Red, green
// and blue are scaled by the brightness register as c*brightness/255
// (truncated) and sent green, red, blue, most significant bit first, as 24
// pulse symbols on out_sym: line high for the one- or zero-bit high time,
// then low for the matching low time. An LED flagged last_led is followed by
// a 25th symbol, low for reset_ticks and then low for 0 ticks. The final
// symbol of every LED carries last. Datapath: the front stage registers the
// three 8x8 products, then divides by 255 with a shift-and-add and queues the
// scaled word; the serialiser reads the queue head and emits one symbol per
// cycle into an output register unless the queue is empty or out_sym stalls.
// The first symbol of an LED passes the product register, a queue slot and
// the output register; sustained, the serialiser's output sets how fast LEDs
// are taken. Back-pressure on out_sym stalls the serialiser; the queue
// (QUEUE_DEPTH entries) lets the front keep taking LEDs until it fills.
// Configuration writes on cfg_wr are always taken (ready held high); indices
// beyond the register list are dropped and wide values keep their low bits.
// Write configuration only while no LED is in flight.
module ws2812_pixel_bit_encoder
  import wsenc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  wsenc_stream_if.sink   in_pix,
  wsenc_stream_if.source out_sym,
  wsenc_stream_if.sink   cfg_wr
);

  logic [7:0]    brightness_r;
  wsenc_timing_t timing_r;
  wsenc_cfg_wr_t cfg;
  wsenc_pix_t    pix;
  wsenc_sym_t    sym;

  logic          push_valid, push_ready, head_valid, pop;
  wsenc_item_t   push_item, head;

  assign cfg          = cfg_wr.data;
  assign pix          = in_pix.data;
  assign cfg_wr.ready = 1'b1;

  // Register file: decode the index, keep the low bits of the value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r       <= BrightnessRst;
      timing_r.zero_high <= ZeroHighRst;
      timing_r.zero_low  <= ZeroLowRst;
      timing_r.one_high  <= OneHighRst;
      timing_r.one_low   <= OneLowRst;
      timing_r.reset_low <= ResetTickRst;
    end else if (cfg_wr.valid) begin
      unique case (cfg.index)
        REG_BRIGHTNESS: brightness_r       <= cfg.value[7:0];
        REG_ZERO_HIGH:  timing_r.zero_high <= cfg.value;
        REG_ZERO_LOW:   timing_r.zero_low  <= cfg.value;
        REG_ONE_HIGH:   timing_r.one_high  <= cfg.value;
        REG_ONE_LOW:    timing_r.one_low   <= cfg.value;
        REG_RESET:      timing_r.reset_low <= cfg.value;
        default: ;
      endcase
    end
  end

  // Front: accept, scale and pack each LED
  wsenc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .brightness (brightness_r),
    .pix_valid  (in_pix.valid),
    .pix_ready  (in_pix.ready),
    .pix        (pix),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Queue between the two halves
  wsenc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .head_valid (head_valid),
    .pop        (pop),
    .head       (head)
  );

  // Back: serialise the head word into pulse symbols
  wsenc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .timing     (timing_r),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_sym.valid),
    .out_ready  (out_sym.ready),
    .out_sym    (sym)
  );

  assign out_sym.data = sym;

endmodule
